>>> rtl/rlp_pkg.sv
package rlp_pkg;

	localparam logic [6:0] LINE_MAX = 7'd64;
	localparam int PAT_COUNT = 4;
	localparam int PAT_DIST = 0;
	localparam int PAT_OUTRAN = 1;
	localparam int PAT_MEDIUM = 2;
	localparam int PAT_THICK = 3;
	localparam logic [6:0] DIST_PREFIX_LEN = 7'd6;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_VT = 8'h0B;
	localparam logic [7:0] CHAR_FF = 8'h0C;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_ARM = 1'b1;

	localparam logic [1:0] KIND_DIST = 2'd0;
	localparam logic [1:0] KIND_OUT_RANGE = 2'd1;
	localparam logic [1:0] KIND_SURFACE = 2'd2;
	localparam logic [1:0] KIND_DROPPED = 2'd3;

	// Pattern texts, one row per pattern, padded with NUL.
	localparam logic [7:0] PAT_TEXT [PAT_COUNT][8] = '{
		'{8'h44, 8'h69, 8'h73, 8'h74, 8'h3A, 8'h20, 8'h00, 8'h00},
		'{8'h4F, 8'h55, 8'h54, 8'h5F, 8'h52, 8'h41, 8'h4E, 8'h00},
		'{8'h4D, 8'h45, 8'h44, 8'h49, 8'h55, 8'h4D, 8'h00, 8'h00},
		'{8'h54, 8'h48, 8'h49, 8'h43, 8'h4B, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [6:0] PAT_LEN [PAT_COUNT] = '{7'd6, 7'd7, 7'd6, 7'd5};

	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_DIGITS,
		NUM_ENDED,
		NUM_NUL
	} num_phase_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [15:0] distance;
		logic        error;
	} rlp_result_t;

endpackage

>>> rtl/rlp_parser.sv
module rlp_parser
	import rlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output rlp_result_t result
);

	logic        holding_q, holding_d;
	logic        error_q, error_d;
	logic [6:0]  pos_q, pos_d;
	logic [3:0]  alive_q, alive_d;
	num_phase_t  phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [15:0] acc_q, acc_d;
	logic        comma_q, comma_d;

	logic [3:0]  hit;
	logic        is_digit;
	logic        is_blank;
	logic [15:0] digit_val;
	logic [15:0] acc_times_ten;

	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
		(rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
	assign digit_val = {12'd0, rx_byte[3:0]};
	assign acc_times_ten = {acc_q[12:0], 3'd0} + {acc_q[14:0], 1'b0};

	always_comb begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			hit[k] = alive_q[k] && (pos_q >= PAT_LEN[k]);
		end
	end

	always_comb begin
		holding_d = holding_q;
		error_d = error_q;
		pos_d = pos_q;
		alive_d = alive_q;
		phase_d = phase_q;
		neg_d = neg_q;
		acc_d = acc_q;
		comma_d = comma_q;
		result = '0;

		if (op == OP_ARM) begin
			holding_d = 1'b0;
			error_d = 1'b0;
			pos_d = '0;
			alive_d = '1;
			phase_d = NUM_SKIP;
			neg_d = 1'b0;
			acc_d = '0;
			comma_d = 1'b0;
		end else if (holding_q || rx_byte == CHAR_CR) begin
			// Ignored while a distance is held, and carriage returns always.
		end else if (rx_byte != CHAR_LF) begin
			for (int k = 0; k < PAT_COUNT; k++) begin
				if (pos_q < PAT_LEN[k] && PAT_TEXT[k][pos_q[2:0]] != rx_byte) begin
					alive_d[k] = 1'b0;
				end
			end
			if (pos_q >= DIST_PREFIX_LEN && phase_q != NUM_NUL) begin
				if (rx_byte == CHAR_NUL) begin
					phase_d = NUM_NUL;
				end else if (rx_byte == CHAR_COMMA) begin
					comma_d = 1'b1;
					phase_d = NUM_ENDED;
				end else if (phase_q == NUM_SKIP) begin
					if (is_blank) begin
						phase_d = NUM_SKIP;
					end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
						neg_d = (rx_byte == CHAR_MINUS);
						phase_d = NUM_DIGITS;
					end else if (is_digit) begin
						acc_d = digit_val;
						phase_d = NUM_DIGITS;
					end else begin
						phase_d = NUM_ENDED;
					end
				end else if (phase_q == NUM_DIGITS) begin
					if (is_digit) begin
						acc_d = acc_times_ten + digit_val;
					end else begin
						phase_d = NUM_ENDED;
					end
				end
			end
			if (pos_q < LINE_MAX) begin
				pos_d = pos_q + 7'd1;
			end
		end else begin
			// A newline ends the line; whatever the outcome, the line state clears.
			pos_d = '0;
			alive_d = '1;
			phase_d = NUM_SKIP;
			neg_d = 1'b0;
			acc_d = '0;
			comma_d = 1'b0;
			if (pos_q >= LINE_MAX) begin
				result.valid = 1'b1;
				result.kind = KIND_DROPPED;
				result.error = error_q;
			end else if (hit[PAT_OUTRAN] || hit[PAT_MEDIUM] || hit[PAT_THICK]) begin
				error_d = 1'b1;
				result.valid = 1'b1;
				result.kind = hit[PAT_OUTRAN] ? KIND_OUT_RANGE : KIND_SURFACE;
				result.error = 1'b1;
			end else if (hit[PAT_DIST]) begin
				holding_d = 1'b1;
				result.valid = 1'b1;
				result.kind = KIND_DIST;
				result.error = error_q;
				if (!comma_q) begin
					result.distance = 16'hFFFF;
				end else if (neg_q) begin
					result.distance = 16'd0 - acc_q;
				end else begin
					result.distance = acc_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			error_q <= 1'b0;
			pos_q <= '0;
			alive_q <= '1;
			phase_q <= NUM_SKIP;
			neg_q <= 1'b0;
			acc_q <= '0;
			comma_q <= 1'b0;
		end else if (en) begin
			holding_q <= holding_d;
			error_q <= error_d;
			pos_q <= pos_d;
			alive_q <= alive_d;
			phase_q <= phase_d;
			neg_q <= neg_d;
			acc_q <= acc_d;
			comma_q <= comma_d;
		end
	end

endmodule

>>> rtl/rlp_out_reg.sv
module rlp_out_reg
	import rlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rlp_result_t result,
	output logic        room,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  line_kind,
	output logic [15:0] distance,
	output logic        error_seen
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [15:0] distance_q;
	logic        error_q;

	// A new result may enter when the register is empty or is being emptied now.
	assign room = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= result.kind;
			distance_q <= result.distance;
			error_q <= result.error;
		end
	end

	assign out_valid = valid_q;
	assign line_kind = kind_q;
	assign distance = distance_q;
	assign error_seen = error_q;

endmodule

>>> rtl/rangefinder_reply_line_parser_top.sv
// Rangefinder reply line parser: takes one UART byte (or an arm request) per cycle while
// not stalled, and reports a result at each newline that ends a recognised or over-long
// line. A request is registered in an input stage, parsed against the running line state,
// and any result lands in an output register; a new request is taken every cycle that the
// input is not stalled. The input stalls only when a request that would give a result
// meets a full output register that is itself stalled. After a distance is reported all
// bytes are ignored until an arm request.
module rangefinder_reply_line_parser_top
	import rlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  line_kind,
	output logic [15:0] distance,
	output logic        error_seen
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        room;
	rlp_result_t result;

	assign adv = valid_s1 && (!result.valid || room);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			byte_s1 <= rx_byte;
		end
	end

	rlp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.result  (result)
	);

	rlp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && result.valid),
		.result     (result),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_kind  (line_kind),
		.distance   (distance),
		.error_seen (error_seen)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rlp_pkg::*;

	typedef struct {
		logic       is_arm;
		logic [7:0] ch;
	} uart_req_t;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] mm;
		logic        err;
	} line_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  line_kind;
	logic [15:0] distance;
	logic        error_seen;

	uart_req_t    uart_reqs [$];
	line_report_t due_reports [$];
	uart_req_t    drive_req;

	int   mismatches = 0;
	int   lines_checked = 0;
	int   in_gap, in_calm, out_hold, out_calm;
	logic hold_off = 1'b0;

	// Running copy of the parser state.
	logic        awaiting_arm;
	logic        fault_sticky;
	logic [6:0]  col;
	logic [3:0]  still_matching;
	num_phase_t  num_state;
	logic        minus;
	logic [15:0] value_mm;
	logic        saw_comma;

	rangefinder_reply_line_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_kind  (line_kind),
		.distance   (distance),
		.error_seen (error_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [6:0] tag_len(int k);
		case (k)
			PAT_DIST:   tag_len = 7'd6;
			PAT_OUTRAN: tag_len = 7'd7;
			PAT_MEDIUM: tag_len = 7'd6;
			default:    tag_len = 7'd5;
		endcase
	endfunction

	function automatic logic [7:0] tag_char(int k, int i);
		logic [55:0] txt;
		case (k)
			PAT_DIST:   txt = "Dist: ";
			PAT_OUTRAN: txt = "OUT_RAN";
			PAT_MEDIUM: txt = "MEDIUM";
			default:    txt = "THICK";
		endcase
		tag_char = txt[8 * (tag_len(k) - 1 - i) +: 8];
	endfunction

	function automatic logic tag_found(int k);
		tag_found = still_matching[k] && col >= tag_len(k);
	endfunction

	task automatic clear_line();
		col = 7'd0;
		still_matching = 4'hF;
		num_state = NUM_SKIP;
		minus = 1'b0;
		value_mm = 16'd0;
		saw_comma = 1'b0;
	endtask

	task automatic reset_predictor();
		awaiting_arm = 1'b0;
		fault_sticky = 1'b0;
		clear_line();
	endtask

	task automatic number_char(input logic [7:0] c);
		logic digit;
		digit = c >= CHAR_ZERO && c <= CHAR_NINE;
		if (num_state != NUM_NUL) begin
			if (c == CHAR_NUL) begin
				num_state = NUM_NUL;
			end else if (c == CHAR_COMMA) begin
				saw_comma = 1'b1;
				num_state = NUM_ENDED;
			end else if (num_state == NUM_SKIP) begin
				if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
				end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
					minus = c == CHAR_MINUS;
					num_state = NUM_DIGITS;
				end else if (digit) begin
					value_mm = {8'd0, c - CHAR_ZERO};
					num_state = NUM_DIGITS;
				end else begin
					num_state = NUM_ENDED;
				end
			end else if (num_state == NUM_DIGITS) begin
				if (digit)
					value_mm = value_mm * 16'd10 + {8'd0, c - CHAR_ZERO};
				else
					num_state = NUM_ENDED;
			end
		end
	endtask

	task automatic parse_request(input logic is_arm, input logic [7:0] c);
		line_report_t rep;
		logic hit_out, hit_surf, hit_dist;
		hit_out = tag_found(PAT_OUTRAN);
		hit_surf = tag_found(PAT_MEDIUM) || tag_found(PAT_THICK);
		hit_dist = tag_found(PAT_DIST);
		rep.mm = 16'd0;
		rep.err = fault_sticky;
		if (is_arm == OP_ARM) begin
			awaiting_arm = 1'b0;
			fault_sticky = 1'b0;
			clear_line();
		end else if (!awaiting_arm && c != CHAR_CR) begin
			if (c != CHAR_LF) begin
				for (int k = 0; k < PAT_COUNT; k++)
					if (col < tag_len(k) && tag_char(k, col) != c)
						still_matching[k] = 1'b0;
				if (col >= DIST_PREFIX_LEN)
					number_char(c);
				if (col < LINE_MAX)
					col = col + 7'd1;
			end else begin
				if (col >= LINE_MAX) begin
					rep.kind = KIND_DROPPED;
					due_reports.push_back(rep);
				end else if (hit_out || hit_surf) begin
					fault_sticky = 1'b1;
					rep.kind = hit_out ? KIND_OUT_RANGE : KIND_SURFACE;
					rep.err = 1'b1;
					due_reports.push_back(rep);
				end else if (hit_dist) begin
					rep.kind = KIND_DIST;
					rep.mm = !saw_comma ? 16'hFFFF : (minus ? 16'd0 - value_mm : value_mm);
					awaiting_arm = 1'b1;
					due_reports.push_back(rep);
				end
				clear_line();
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_line();
		line_report_t want;
		if (due_reports.size() == 0) begin
			report_mismatch("unexpected result, kind", line_kind, -1);
		end else begin
			want = due_reports.pop_front();
			if (line_kind !== want.kind)
				report_mismatch("line_kind", line_kind, want.kind);
			if (distance !== want.mm)
				report_mismatch("distance", distance, want.mm);
			if (error_seen !== want.err)
				report_mismatch("error_seen", error_seen, want.err);
		end
	endtask

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			pick_pause = 0;
		else if (r < 93)
			pick_pause = $urandom_range(1, 3);
		else
			pick_pause = $urandom_range(8, 40);
	endfunction

	// Sender: one request on the bus at a time, held until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_BYTE;
			rx_byte <= 8'h00;
			in_gap <= 0;
			in_calm <= 0;
			reset_predictor();
		end else begin
			if (in_valid && !in_stall)
				parse_request(op, rx_byte);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (uart_reqs.size() > 0) begin
					drive_req = uart_reqs.pop_front();
					op <= drive_req.is_arm;
					rx_byte <= drive_req.ch;
					in_valid <= 1'b1;
					if (hold_off || in_calm > 0)
						in_gap <= 0;
					else
						in_gap <= pick_pause();
					if (in_calm > 0)
						in_calm <= in_calm - 1;
					else if ($urandom_range(0, 49) == 0)
						in_calm <= $urandom_range(30, 120);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result taken and stalls at random.
	always @(posedge clk or negedge arst_n) begin : receiver
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
			out_calm <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_line();
				lines_checked <= lines_checked + 1;
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold <= out_hold - 1;
			end else begin
				n = out_calm > 0 ? 0 : pick_pause();
				out_stall <= n > 0;
				if (n > 0)
					out_hold <= n - 1;
			end
			if (out_calm > 0)
				out_calm <= out_calm - 1;
			else if ($urandom_range(0, 49) == 0)
				out_calm <= $urandom_range(30, 120);
		end
	end

	// A long hold-off on the result side so that the block fills and stalls its input.
	initial begin
		while (lines_checked < 40)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (400)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] any_but_lf();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CHAR_LF)
			b = CHAR_CR;
		any_but_lf = b;
	endfunction

	task automatic queue_byte(input logic [7:0] c);
		uart_req_t r;
		r.is_arm = OP_BYTE;
		r.ch = c;
		uart_reqs.push_back(r);
	endtask

	task automatic queue_arm();
		uart_req_t r;
		r.is_arm = OP_ARM;
		r.ch = 8'($urandom_range(0, 255));
		uart_reqs.push_back(r);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	task automatic queue_line(input string s);
		queue_text(s);
		if ($urandom_range(0, 1))
			queue_byte(CHAR_CR);
		queue_byte(CHAR_LF);
	endtask

	task automatic queue_blank();
		case ($urandom_range(0, 3))
			0: queue_byte(CHAR_SPACE);
			1: queue_byte(CHAR_TAB);
			2: queue_byte(CHAR_VT);
			default: queue_byte(CHAR_FF);
		endcase
	endtask

	// A line with a fixed start, filled with random bytes to the given length.
	task automatic queue_padded(input string head, input int total);
		queue_text(head);
		for (int i = head.len(); i < total; i++)
			queue_byte(any_but_lf());
		queue_byte(CHAR_LF);
	endtask

	task automatic queue_range_line();
		int r;
		r = $urandom_range(0, 9);
		queue_text("Dist: ");
		repeat ($urandom_range(0, 2))
			queue_blank();
		if (r < 2)
			queue_byte(CHAR_MINUS);
		else if (r == 2)
			queue_byte(CHAR_PLUS);
		repeat ($urandom_range(0, 6))
			queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 9) == 0)
			queue_byte(CHAR_NUL);
		if ($urandom_range(0, 9) == 0)
			queue_byte(any_but_lf());
		if ($urandom_range(0, 9) < 8)
			queue_byte(CHAR_COMMA);
		repeat ($urandom_range(0, 5))
			queue_byte(any_but_lf());
		queue_line("");
	endtask

	// An error line, sometimes cut short or with one character spoilt.
	task automatic queue_fault_line();
		string s;
		int cut, bad;
		case ($urandom_range(0, 2))
			0: s = "OUT_RAN";
			1: s = "MEDIUM";
			default: s = "THICK";
		endcase
		cut = $urandom_range(0, 9) == 0 ? $urandom_range(0, s.len() - 1) : s.len();
		bad = $urandom_range(0, 6) == 0 ? $urandom_range(0, s.len() - 1) : -1;
		for (int i = 0; i < cut; i++)
			queue_byte(i == bad ? any_but_lf() : s[i]);
		repeat ($urandom_range(0, 4))
			queue_byte(any_but_lf());
		queue_line("");
	endtask

	initial begin
		int pick;

		queue_line("Dist: 1234,");
		queue_line("OUT_RAN");
		queue_arm();
		queue_line("OUT_RAN");
		queue_line("MEDIUM");
		queue_line("THICK xyz");
		queue_line("Dist: -5,");
		queue_arm();
		queue_text("Dist: ");
		queue_byte(CHAR_TAB);
		queue_byte(CHAR_VT);
		queue_byte(CHAR_FF);
		queue_byte(CHAR_SPACE);
		queue_line("+70000,");
		queue_arm();
		queue_line("Dist: 12");
		queue_arm();
		queue_line("Dist: ,");
		queue_arm();
		queue_text("Dist: 12");
		queue_byte(CHAR_NUL);
		queue_line(",9");
		queue_arm();
		queue_line("Dist: 1a2,5");
		queue_arm();
		queue_line("Dist: -,");
		queue_arm();
		queue_line("Dist: 65535,");
		queue_arm();
		queue_line("OUT_RA");
		queue_line("THIC");
		queue_line("Dist:");
		queue_line("");
		queue_byte(8'hFF);
		queue_byte(CHAR_NUL);
		queue_line("");
		queue_text("OUT");
		queue_byte(CHAR_CR);
		queue_line("_RAN");
		queue_padded("OUT_RAN", int'(LINE_MAX) - 1);
		queue_padded("OUT_RAN", int'(LINE_MAX));
		queue_padded("Dist: 7,", int'(LINE_MAX) + 3);
		queue_line("Dist: 9,");
		queue_arm();

		while (uart_reqs.size() < 1850) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				queue_range_line();
				if ($urandom_range(0, 9) < 8)
					queue_arm();
			end else if (pick < 65) begin
				queue_fault_line();
			end else if (pick < 73) begin
				case ($urandom_range(0, 2))
					0: queue_padded("", $urandom_range(int'(LINE_MAX) - 3, int'(LINE_MAX) + 6));
					1: queue_padded("OUT_RAN", $urandom_range(int'(LINE_MAX) - 3, int'(LINE_MAX) + 6));
					default: queue_padded("Dist: 3,", $urandom_range(int'(LINE_MAX) - 3, int'(LINE_MAX) + 6));
				endcase
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6))
					queue_byte(8'($urandom_range(0, 255)));
				queue_byte(CHAR_LF);
			end else begin
				queue_arm();
			end
		end

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		while (uart_reqs.size() > 0 || in_valid)
			@(posedge clk);
		while (due_reports.size() > 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
